// File: hw/rtl/weno_face_reconstruction_defines.svh
// Assertion helpers for the WENO face reconstruction block.
// Each macro expects clk and rst to be visible at the place of use.
`ifndef WENO_FACE_RECONSTRUCTION_DEFINES_SVH
`define WENO_FACE_RECONSTRUCTION_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define WFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("weno_face_reconstruction: same-cycle check failed");

// Condition must hold in the cycle after the trigger.
`define WFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("weno_face_reconstruction: next-cycle check failed");

`endif

// File: hw/rtl/wfr_pkg.sv
package wfr_pkg;

  // Stencil and sample format (signed Q8.24)
  localparam int STENCIL_POINTS = 7;
  localparam int SAMPLE_BITS    = 32;
  localparam int USED_POINTS    = 5;
  localparam int FACES          = 2;
  localparam int TRIPLE_K       = 3;
  localparam int TRIPLES        = FACES * TRIPLE_K;

  localparam int IN_TDATA_W  = STENCIL_POINTS * SAMPLE_BITS;
  localparam int OUT_TDATA_W = 3 * SAMPLE_BITS;

  // Epsilon register, Q16.48 units
  localparam int EPS_W = 32;
  localparam logic [EPS_W-1:0] EPS_RESET = 32'd28147;

  // Datapath widths
  localparam int CAND_W  = 38;  // candidate sums, six times the face value
  localparam int TE_W    = 36;  // first-tap difference
  localparam int E_W     = 35;  // second difference
  localparam int TABS_W  = 35;
  localparam int EABS_W  = 34;
  localparam int SQ_LO   = 18;  // split point for squaring
  localparam int T2_W    = 68;
  localparam int E2_W    = 66;
  localparam int CHUNK_W = 8;
  localparam int D3_W    = 72;  // indicator numerator / 4, padded to chunks
  localparam int D3_PER  = 3;   // chunks per stage
  localparam int D3_STAGES = D3_W / (CHUNK_W * D3_PER);
  localparam int DEN_W   = 64;
  localparam int CQ_W    = 31;
  localparam int ALPHA_QBITS = CQ_W + DEN_W;
  localparam int SUM_W   = ALPHA_QBITS + 2;
  localparam int OMEGA_QBITS = 33;
  localparam int CABS_W  = 37;
  localparam int CL_W    = 19;
  localparam int CH_W    = CABS_W - CL_W;
  localparam int PROD_W  = OMEGA_QBITS + CABS_W;
  localparam int SPROD_W = PROD_W + 1;
  localparam int ACC_W   = SPROD_W + 2;
  localparam int Y_W     = ACC_W - 32;
  localparam int F_W     = 40;  // final quotient word, five chunks
  localparam int F_STAGES = 2;
  localparam int RES_W   = 41;
  localparam int SIDE_BITS = TRIPLES * CAND_W;

  // Linear weights C_k in Q0.32
  localparam logic [CQ_W-1:0] WEIGHT_Q [TRIPLE_K] = '{
    31'd406508114, 31'd1838564742, 31'd1753589326
  };

  localparam logic signed [RES_W-1:0] SAT_HI =
    {{(RES_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [RES_W-1:0] SAT_LO =
    {{(RES_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // One base-256 digit of a division by three: {quotient digit, remainder}
  function automatic logic [CHUNK_W+1:0] div3_step(input logic [1:0] rem,
                                                   input logic [CHUNK_W-1:0] chunk);
    logic [9:0]  v;
    logic [20:0] prod;
    logic [7:0]  q;
    logic [9:0]  r;
    v    = {rem, chunk};
    prod = 21'(v) * 21'd683;
    q    = prod[18:11];
    r    = v - {1'b0, q, 1'b0} - {2'b00, q};
    return {q, r[1:0]};
  endfunction

  // Clamp to the sample range
  function automatic sample_t sat_sample(input logic signed [RES_W-1:0] x);
    sample_t r;
    if (x > SAT_HI) begin
      r = SAT_HI[SAMPLE_BITS-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      r = x[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/wfr_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Dividend bits are fed from feed_in MSB first onto the running remainder.
module wfr_div_pipe import wfr_pkg::*; #(
  parameter int LANES  = TRIPLES,
  parameter int QBITS  = ALPHA_QBITS,
  parameter int DBITS  = DEN_W,
  parameter int SIDE_W = SIDE_BITS
) (
  input  logic              clk,
  input  logic              adv,
  input  logic [DBITS-1:0]  rem_in  [LANES],
  input  logic [QBITS-1:0]  feed_in [LANES],
  input  logic [DBITS-1:0]  div_in  [LANES],
  input  logic [SIDE_W-1:0] side_in,
  output logic [QBITS-1:0]  quo_out [LANES],
  output logic [SIDE_W-1:0] side_out
);

  logic [DBITS-1:0]  rem_s  [QBITS][LANES];
  logic [QBITS-1:0]  feed_s [QBITS][LANES];
  logic [DBITS-1:0]  div_s  [QBITS][LANES];
  logic [QBITS-1:0]  quo_s  [QBITS+1][LANES];
  logic [SIDE_W-1:0] side_s [QBITS+1];

  // stage zero is the input
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_s[0][l]  = rem_in[l];
      feed_s[0][l] = feed_in[l];
      div_s[0][l]  = div_in[l];
      quo_s[0][l]  = '0;
    end
    side_s[0] = side_in;
  end

  for (genvar s = 0; s < QBITS; s++) begin : g_step
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DBITS:0] trial;
      logic [DBITS:0] diff;
      logic           ge;

      // trial subtract of the divisor
      always_comb begin
        trial = {rem_s[s][l], feed_s[s][l][QBITS-1]};
        diff  = trial - {1'b0, div_s[s][l]};
        ge    = (trial >= {1'b0, div_s[s][l]});
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          quo_s[s+1][l] <= {quo_s[s][l][QBITS-2:0], ge};
        end
      end

      if (s < QBITS - 1) begin : g_pass
        always_ff @(posedge clk) begin
          if (adv) begin
            rem_s[s+1][l]  <= ge ? diff[DBITS-1:0] : trial[DBITS-1:0];
            feed_s[s+1][l] <= {feed_s[s][l][QBITS-2:0], 1'b0};
            div_s[s+1][l]  <= div_s[s][l];
          end
        end
      end
    end

    // data riding alongside
    always_ff @(posedge clk) begin
      if (adv) begin
        side_s[s+1] <= side_s[s];
      end
    end
  end

  assign quo_out  = quo_s[QBITS];
  assign side_out = side_s[QBITS];

endmodule

// File: hw/rtl/weno_face_reconstruction.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: cell_m3..cell_p3, 32 bits each
// m_*       out  m_tvalid/m_tready  m_tdata: face_high, face_low, cell_slope
// cfg_*     in   cfg_wr_en          cfg_wr_data: smooth_epsilon
//
// One item per cycle unless m_tready stalls the pipe; the two bit-serial divider
// pipelines have 95 stages for the raw weights and 33 for normalization.
// Reset clears the valid bits and loads the epsilon default; data regs are not reset.
// A stall on m_tready freezes every stage at once; nothing is dropped or repeated.
`include "weno_face_reconstruction_defines.svh"

module weno_face_reconstruction import wfr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [EPS_W-1:0]       cfg_wr_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // cell_m3, cell_m2, cell_m1, cell_c, cell_p1, cell_p2, cell_p3 (low bits first)
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // face_high, face_low, cell_slope (low bits first)
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int PRE_STAGES = 9;
  localparam int PIPE_DEPTH = PRE_STAGES + ALPHA_QBITS + 1 + OMEGA_QBITS + 7;
  localparam int V_DEN   = PRE_STAGES - 1;
  localparam int V_OMEGA = PRE_STAGES + ALPHA_QBITS + OMEGA_QBITS;
  localparam int CAND_DL = PRE_STAGES - 1;
  localparam logic signed [Y_W-1:0] Z_OFFSET = Y_W'(3) << 36;
  localparam logic signed [RES_W-1:0] RES_OFFSET = RES_W'(1) << 35;

  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld;
  logic [EPS_W-1:0]      smooth_epsilon;

  // global advance
  assign adv      = !vld[PIPE_DEPTH-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_epsilon <= EPS_RESET;
    end else if (cfg_wr_en) begin
      smooth_epsilon <= cfg_wr_data;
    end
  end

  // input register: the five cells that matter
  sample_t cell_s [USED_POINTS];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < USED_POINTS; i++) begin
        cell_s[i] <= s_tdata[(i+1)*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
  end

  // taps and candidates; low face reads the cells mirrored
  logic signed [TE_W-1:0]   te_t_next [TRIPLES];
  logic signed [E_W-1:0]    te_e_next [TRIPLES];
  logic signed [CAND_W-1:0] cand_next [TRIPLES];
  logic signed [TE_W-1:0]   te_t [TRIPLES];
  logic signed [E_W-1:0]    te_e [TRIPLES];
  logic signed [CAND_W-1:0] cand_dl [CAND_DL][TRIPLES];

  always_comb begin
    logic signed [CAND_W-1:0] a, b, c, t, e, q;
    for (int f = 0; f < FACES; f++) begin
      for (int k = 0; k < TRIPLE_K; k++) begin
        a = CAND_W'(cell_s[f == 0 ? k     : 4 - k]);
        b = CAND_W'(cell_s[f == 0 ? k + 1 : 3 - k]);
        c = CAND_W'(cell_s[f == 0 ? k + 2 : 2 - k]);
        e = a - (b <<< 1) + c;
        case (k)
          0: begin
            t = a - (b <<< 2) + 38'sd3 * c;
            q = (a <<< 1) - 38'sd7 * b + 38'sd11 * c;
          end
          1: begin
            t = c - a;
            q = -a + 38'sd5 * b + (c <<< 1);
          end
          default: begin
            t = -(38'sd3 * a) + (b <<< 2) - c;
            q = (a <<< 1) + 38'sd5 * b - c;
          end
        endcase
        te_t_next[f*TRIPLE_K+k] = t[TE_W-1:0];
        te_e_next[f*TRIPLE_K+k] = e[E_W-1:0];
        cand_next[f*TRIPLE_K+k] = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      te_t       <= te_t_next;
      te_e       <= te_e_next;
      cand_dl[0] <= cand_next;
      for (int d = 1; d < CAND_DL; d++) begin
        cand_dl[d] <= cand_dl[d-1];
      end
    end
  end

  // squaring, partial products
  logic [2*(TABS_W-SQ_LO)-1:0]  thh [TRIPLES];
  logic [TABS_W-1:0]            thl [TRIPLES];
  logic [2*SQ_LO-1:0]           tll [TRIPLES];
  logic [2*(EABS_W-SQ_LO)-1:0]  ehh [TRIPLES];
  logic [EABS_W-1:0]            ehl [TRIPLES];
  logic [2*SQ_LO-1:0]           ell [TRIPLES];

  always_ff @(posedge clk) begin
    logic [TE_W-1:0] tn;
    logic [E_W-1:0]  en;
    logic [TABS_W-1:0] ta;
    logic [EABS_W-1:0] ea;
    if (adv) begin
      for (int j = 0; j < TRIPLES; j++) begin
        tn = te_t[j][TE_W-1] ? -te_t[j] : te_t[j];
        en = te_e[j][E_W-1] ? -te_e[j] : te_e[j];
        ta = tn[TABS_W-1:0];
        ea = en[EABS_W-1:0];
        thh[j] <= ta[TABS_W-1:SQ_LO] * ta[TABS_W-1:SQ_LO];
        thl[j] <= ta[TABS_W-1:SQ_LO] * ta[SQ_LO-1:0];
        tll[j] <= ta[SQ_LO-1:0] * ta[SQ_LO-1:0];
        ehh[j] <= ea[EABS_W-1:SQ_LO] * ea[EABS_W-1:SQ_LO];
        ehl[j] <= ea[EABS_W-1:SQ_LO] * ea[SQ_LO-1:0];
        ell[j] <= ea[SQ_LO-1:0] * ea[SQ_LO-1:0];
      end
    end
  end

  // recombine squares
  logic [T2_W-1:0] t2 [TRIPLES];
  logic [E2_W-1:0] e2 [TRIPLES];
  always_ff @(posedge clk) begin
    logic [69:0] tw, ew;
    if (adv) begin
      for (int j = 0; j < TRIPLES; j++) begin
        tw = (70'(thh[j]) << (2*SQ_LO)) + (70'(thl[j]) << (SQ_LO+1)) + 70'(tll[j]);
        ew = (70'(ehh[j]) << (2*SQ_LO)) + (70'(ehl[j]) << (SQ_LO+1)) + 70'(ell[j]);
        t2[j] <= tw[T2_W-1:0];
        e2[j] <= ew[E2_W-1:0];
      end
    end
  end

  // 3 t^2 + 13 e^2, then divide by four
  logic [D3_W-1:0] n4 [TRIPLES];
  always_ff @(posedge clk) begin
    logic [70:0] n;
    if (adv) begin
      for (int j = 0; j < TRIPLES; j++) begin
        n = 71'(t2[j]) * 71'd3 + 71'(e2[j]) * 71'd13;
        n4[j] <= {3'b000, n[70:2]};
      end
    end
  end

  // divide by three, a digit at a time, quotient replaces dividend in place
  logic [D3_W-1:0] d3_w [D3_STAGES][TRIPLES];
  logic [1:0]      d3_r [D3_STAGES][TRIPLES];

  for (genvar g = 0; g < D3_STAGES; g++) begin : g_d3
    logic [D3_W-1:0] w_in [TRIPLES];
    logic [1:0]      r_in [TRIPLES];
    if (g == 0) begin : g_first
      always_comb begin
        for (int j = 0; j < TRIPLES; j++) begin
          w_in[j] = n4[j];
          r_in[j] = 2'b00;
        end
      end
    end else begin : g_rest
      always_comb begin
        for (int j = 0; j < TRIPLES; j++) begin
          w_in[j] = d3_w[g-1][j];
          r_in[j] = d3_r[g-1][j];
        end
      end
    end

    always_ff @(posedge clk) begin
      logic [D3_W-1:0] w;
      logic [1:0]      r;
      logic [CHUNK_W+1:0] st;
      if (adv) begin
        for (int j = 0; j < TRIPLES; j++) begin
          w = w_in[j];
          r = r_in[j];
          for (int c = 0; c < D3_PER; c++) begin
            st = div3_step(r, w[D3_W-CHUNK_W*(g*D3_PER+c+1) +: CHUNK_W]);
            w[D3_W-CHUNK_W*(g*D3_PER+c+1) +: CHUNK_W] = st[CHUNK_W+1:2];
            r = st[1:0];
          end
          d3_w[g][j] <= w;
          d3_r[g][j] <= r;
        end
      end
    end
  end

  // indicator saturation, epsilon, zero guard
  logic [DEN_W-1:0] den_r [TRIPLES];
  always_ff @(posedge clk) begin
    logic [D3_W-1:0]  isq;
    logic [DEN_W-1:0] is64, den;
    logic [DEN_W:0]   s65;
    if (adv) begin
      for (int j = 0; j < TRIPLES; j++) begin
        isq  = d3_w[D3_STAGES-1][j];
        is64 = (|isq[D3_W-1:DEN_W]) ? '1 : isq[DEN_W-1:0];
        s65  = {1'b0, is64} + (DEN_W+1)'(smooth_epsilon);
        den  = s65[DEN_W] ? '1 : s65[DEN_W-1:0];
        if (den == '0) begin
          den = DEN_W'(1);
        end
        den_r[j] <= den;
      end
    end
  end

  // raw weights alpha_k = C_k * 2^64 / den
  logic [DEN_W-1:0]       a_rem  [TRIPLES];
  logic [ALPHA_QBITS-1:0] a_feed [TRIPLES];
  logic [ALPHA_QBITS-1:0] alpha  [TRIPLES];
  logic [SIDE_BITS-1:0]   a_side_in, a_side_out;

  always_comb begin
    for (int j = 0; j < TRIPLES; j++) begin
      a_rem[j]  = '0;
      a_feed[j] = {WEIGHT_Q[j % TRIPLE_K], {DEN_W{1'b0}}};
      a_side_in[j*CAND_W +: CAND_W] = cand_dl[CAND_DL-1][j];
    end
  end

  wfr_div_pipe #(
    .LANES (TRIPLES),
    .QBITS (ALPHA_QBITS),
    .DBITS (DEN_W),
    .SIDE_W(SIDE_BITS)
  ) u_alpha_div (
    .clk     (clk),
    .adv     (adv),
    .rem_in  (a_rem),
    .feed_in (a_feed),
    .div_in  (den_r),
    .side_in (a_side_in),
    .quo_out (alpha),
    .side_out(a_side_out)
  );

  // per-face weight sum
  logic [ALPHA_QBITS-1:0] alpha_r [TRIPLES];
  logic [SUM_W-1:0]       sum_r   [FACES];
  logic [SIDE_BITS-1:0]   side_sum;
  always_ff @(posedge clk) begin
    if (adv) begin
      alpha_r  <= alpha;
      side_sum <= a_side_out;
      for (int f = 0; f < FACES; f++) begin
        sum_r[f] <= SUM_W'(alpha[f*TRIPLE_K]) + SUM_W'(alpha[f*TRIPLE_K+1])
                  + SUM_W'(alpha[f*TRIPLE_K+2]);
      end
    end
  end

  // normalized weights omega_k = alpha_k * 2^32 / sum
  logic [SUM_W-1:0]       o_rem  [TRIPLES];
  logic [OMEGA_QBITS-1:0] o_feed [TRIPLES];
  logic [SUM_W-1:0]       o_div  [TRIPLES];
  logic [OMEGA_QBITS-1:0] omega  [TRIPLES];
  logic [SIDE_BITS-1:0]   o_side_out;

  always_comb begin
    for (int j = 0; j < TRIPLES; j++) begin
      o_rem[j]  = SUM_W'(alpha_r[j][ALPHA_QBITS-1:1]);
      o_feed[j] = {alpha_r[j][0], {(OMEGA_QBITS-1){1'b0}}};
      o_div[j]  = sum_r[j / TRIPLE_K];
    end
  end

  wfr_div_pipe #(
    .LANES (TRIPLES),
    .QBITS (OMEGA_QBITS),
    .DBITS (SUM_W),
    .SIDE_W(SIDE_BITS)
  ) u_omega_div (
    .clk     (clk),
    .adv     (adv),
    .rem_in  (o_rem),
    .feed_in (o_feed),
    .div_in  (o_div),
    .side_in (side_sum),
    .quo_out (omega),
    .side_out(o_side_out)
  );

  // weight times candidate, two partial products
  logic [OMEGA_QBITS+CL_W-1:0] p_lo [TRIPLES];
  logic [OMEGA_QBITS+CH_W-1:0] p_hi [TRIPLES];
  logic                        p_neg [TRIPLES];
  always_ff @(posedge clk) begin
    logic signed [CAND_W-1:0] cv;
    logic [CAND_W-1:0]        ca;
    if (adv) begin
      for (int j = 0; j < TRIPLES; j++) begin
        cv = o_side_out[j*CAND_W +: CAND_W];
        ca = cv[CAND_W-1] ? -cv : cv;
        p_lo[j]  <= omega[j] * ca[CL_W-1:0];
        p_hi[j]  <= omega[j] * ca[CABS_W-1:CL_W];
        p_neg[j] <= cv[CAND_W-1];
      end
    end
  end

  logic signed [SPROD_W-1:0] sprod [TRIPLES];
  always_ff @(posedge clk) begin
    logic [PROD_W-1:0] mag;
    if (adv) begin
      for (int j = 0; j < TRIPLES; j++) begin
        mag = (PROD_W'(p_hi[j]) << CL_W) + PROD_W'(p_lo[j]);
        sprod[j] <= p_neg[j] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
    end
  end

  // blend and round half up; keep the integer part
  logic signed [Y_W-1:0] y_r [FACES];
  always_ff @(posedge clk) begin
    logic signed [ACC_W-1:0] acc;
    if (adv) begin
      for (int f = 0; f < FACES; f++) begin
        acc = ACC_W'(sprod[f*TRIPLE_K]) + ACC_W'(sprod[f*TRIPLE_K+1])
            + ACC_W'(sprod[f*TRIPLE_K+2]) + (ACC_W'(3) << 32);
        y_r[f] <= acc[ACC_W-1:32];
      end
    end
  end

  // floor divide by six: offset to nonnegative, halve, then divide by three
  logic [F_W-1:0] f_w [F_STAGES][FACES];
  logic [1:0]     f_r [F_STAGES][FACES];
  always_ff @(posedge clk) begin
    logic signed [Y_W-1:0] z;
    logic [F_W-1:0]        w;
    logic [1:0]            r;
    logic [CHUNK_W+1:0]    st;
    if (adv) begin
      for (int f = 0; f < FACES; f++) begin
        z = y_r[f] + Z_OFFSET;
        w = F_W'(z[Y_W-1:1]);
        r = 2'b00;
        for (int c = 0; c < 3; c++) begin
          st = div3_step(r, w[F_W-CHUNK_W*(c+1) +: CHUNK_W]);
          w[F_W-CHUNK_W*(c+1) +: CHUNK_W] = st[CHUNK_W+1:2];
          r = st[1:0];
        end
        f_w[0][f] <= w;
        f_r[0][f] <= r;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [F_W-1:0]     w;
    logic [1:0]         r;
    logic [CHUNK_W+1:0] st;
    if (adv) begin
      for (int f = 0; f < FACES; f++) begin
        w = f_w[0][f];
        r = f_r[0][f];
        for (int c = 3; c < 5; c++) begin
          st = div3_step(r, w[F_W-CHUNK_W*(c+1) +: CHUNK_W]);
          w[F_W-CHUNK_W*(c+1) +: CHUNK_W] = st[CHUNK_W+1:2];
          r = st[1:0];
        end
        f_w[1][f] <= w;
        f_r[1][f] <= r;
      end
    end
  end

  // remove the offset and clamp each face
  sample_t face_r [FACES];
  always_ff @(posedge clk) begin
    logic signed [RES_W-1:0] res;
    if (adv) begin
      for (int f = 0; f < FACES; f++) begin
        res = $signed(RES_W'(f_w[1][f])) - RES_OFFSET;
        face_r[f] <= sat_sample(res);
      end
    end
  end

  // output register: faces and their clamped difference
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {sat_sample(RES_W'(face_r[0]) - RES_W'(face_r[1])), face_r[1], face_r[0]};
    end
  end

  // checks on the arithmetic
  logic den_ok;
  logic omega_ok;
  always_comb begin
    logic [OMEGA_QBITS:0] osum;
    den_ok   = 1'b1;
    omega_ok = 1'b1;
    for (int j = 0; j < TRIPLES; j++) begin
      if (den_r[j] == '0) begin
        den_ok = 1'b0;
      end
    end
    for (int f = 0; f < FACES; f++) begin
      osum = (OMEGA_QBITS+1)'(omega[f*TRIPLE_K]) + (OMEGA_QBITS+1)'(omega[f*TRIPLE_K+1])
           + (OMEGA_QBITS+1)'(omega[f*TRIPLE_K+2]);
      if (osum > ((OMEGA_QBITS+1)'(1) << 32) ||
          osum < (((OMEGA_QBITS+1)'(1) << 32) - (OMEGA_QBITS+1)'(2))) begin
        omega_ok = 1'b0;
      end
    end
  end

  `WFR_ASSERT_NEXT(a_stall_freeze, !adv, $stable(vld))
  `WFR_ASSERT_NOW(a_den_nonzero, vld[V_DEN], den_ok)
  `WFR_ASSERT_NOW(a_omega_norm, vld[V_OMEGA], omega_ok)

endmodule
